// ===== sv/pdc_pkg.sv =====
`timescale 1ns / 1ps
package pdc_pkg;

    localparam int unsigned SIDE         = 5;
    localparam int unsigned CELLS        = 25;
    localparam int unsigned LETTER_COUNT = 26;

    // letter indexes
    localparam logic [4:0] IDX_I = 5'd8;
    localparam logic [4:0] IDX_J = 5'd9;
    localparam logic [4:0] IDX_X = 5'd23;
    localparam logic [4:0] IDX_LAST = 5'(LETTER_COUNT - 1);
    localparam logic [4:0] CELL_LIMIT = 5'(CELLS);

    // ascii codes
    localparam logic [7:0] ASCII_UC_A = 8'h41;
    localparam logic [7:0] ASCII_UC_Z = 8'h5a;
    localparam logic [7:0] ASCII_LC_A = 8'h61;
    localparam logic [7:0] ASCII_LC_Z = 8'h7a;

    // command codes
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_KEY   = 2'd1;
    localparam logic [1:0] CMD_TEXT  = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic load_item;     // capture the accepted transaction
        logic clear;         // clear square and pair state
        logic place_key;     // place the captured key letter
        logic place_walk;    // place the walk letter, advance the walk
        logic set_complete;  // square is full
        logic pair_load;     // pair operands from held letter and b
        logic pair_b_x;      // second operand is x instead of the item letter
        logic pair_last;     // second output letter of the pair ends the message
        logic hold_set;      // hold the item letter
        logic hold_clear;    // drop the held letter
        logic pos_read;      // read positions of both operands
        logic sq_read;       // read the two output cells
        logic out_load;      // load the output register
        logic out_second;    // select the second letter of the pair
    } t_ctrl;

    // datapath to controller
    typedef struct packed {
        logic [1:0] cmd;
        logic       letter_ok;
        logic       last;
        logic       complete;
        logic       held_valid;
        logic       held_eq;
        logic       mode;
        logic       walk_end;
        logic       out_free;
    } t_stat;

    function automatic logic [2:0] pos_row(input logic [4:0] p);
        logic [2:0] r;
        if (p >= 5'd20)      r = 3'd4;
        else if (p >= 5'd15) r = 3'd3;
        else if (p >= 5'd10) r = 3'd2;
        else if (p >= 5'd5)  r = 3'd1;
        else                 r = 3'd0;
        return r;
    endfunction

    function automatic logic [2:0] pos_col(input logic [4:0] p);
        logic [2:0] r;
        logic [4:0] base;
        r    = pos_row(p);
        base = 5'({r, 2'b00}) + 5'(r);
        return 3'(p - base);
    endfunction

    // one step right/down (encrypt) or left/up (decrypt), wrapping
    function automatic logic [2:0] shift_step(input logic [2:0] v, input logic dec);
        logic [2:0] r;
        if (!dec) r = (v == 3'(SIDE - 1)) ? 3'd0 : 3'(v + 3'd1);
        else      r = (v == 3'd0) ? 3'(SIDE - 1) : 3'(v - 3'd1);
        return r;
    endfunction

    function automatic logic [4:0] cell_of(input logic [2:0] row, input logic [2:0] col);
        return 5'({row, 2'b00}) + 5'(row) + 5'(col);
    endfunction

endpackage

// ===== sv/pdc_ctrl.sv =====
`timescale 1ns / 1ps
module pdc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  pdc_pkg::t_stat i_stat,
    output pdc_pkg::t_ctrl o_ctrl
);
    import pdc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_WALK,
        S_TEXT,
        S_FLUSH,
        S_POS,
        S_SQ,
        S_OUT1,
        S_OUT2
    } t_state;

    t_state r_state, n_state;
    logic   r_more, n_more;
    t_ctrl  c;

    always_comb begin
        c       = '0;
        n_state = r_state;
        n_more  = r_more;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    c.load_item = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_IDLE;
                if (i_stat.cmd == CMD_CLEAR) begin
                    c.clear = 1'b1;
                end else if (i_stat.cmd == CMD_KEY) begin
                    c.place_key = i_stat.letter_ok && !i_stat.complete;
                end else if (i_stat.cmd == CMD_TEXT) begin
                    n_state = i_stat.complete ? S_TEXT : S_WALK;
                end
            end
            S_WALK: begin
                c.place_walk = 1'b1;
                if (i_stat.walk_end) begin
                    c.set_complete = 1'b1;
                    n_state        = S_TEXT;
                end
            end
            S_TEXT: begin
                n_more  = 1'b0;
                n_state = S_IDLE;
                if (i_stat.letter_ok && i_stat.held_valid) begin
                    c.pair_load = 1'b1;
                    n_state     = S_POS;
                    if (!i_stat.mode && i_stat.held_eq) begin
                        // doubled letter: split by x, keep the new one held
                        c.pair_b_x = 1'b1;
                        c.hold_set = 1'b1;
                        n_more     = i_stat.last;
                    end else begin
                        c.pair_last  = i_stat.last;
                        c.hold_clear = 1'b1;
                    end
                end else if (i_stat.letter_ok) begin
                    c.hold_set = 1'b1;
                    if (i_stat.last) n_state = S_FLUSH;
                end else if (i_stat.last && i_stat.held_valid) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                c.pair_load  = 1'b1;
                c.pair_b_x   = 1'b1;
                c.pair_last  = 1'b1;
                c.hold_clear = 1'b1;
                n_more       = 1'b0;
                n_state      = S_POS;
            end
            S_POS: begin
                c.pos_read = 1'b1;
                n_state    = S_SQ;
            end
            S_SQ: begin
                c.sq_read = 1'b1;
                n_state   = S_OUT1;
            end
            S_OUT1: begin
                if (i_stat.out_free) begin
                    c.out_load = 1'b1;
                    n_state    = S_OUT2;
                end
            end
            S_OUT2: begin
                if (i_stat.out_free) begin
                    c.out_load   = 1'b1;
                    c.out_second = 1'b1;
                    n_state      = r_more ? S_FLUSH : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_ctrl = c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_more  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_more  <= n_more;
        end
    end

endmodule

// ===== sv/pdc_datapath.sv =====
`timescale 1ns / 1ps
module pdc_datapath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_wr_en,
    input  logic           i_cfg_wr_data,
    input  logic [1:0]     i_cmd,
    input  logic [7:0]     i_letter,
    input  logic           i_last,
    input  pdc_pkg::t_ctrl i_ctrl,
    output pdc_pkg::t_stat o_stat,
    output logic [6:0]     o_out_letter,
    output logic           o_out_last,
    output logic           o_out_valid,
    input  logic           i_out_ready
);
    import pdc_pkg::*;

    // square and position stores
    logic [4:0] key_square      [CELLS];
    logic [4:0] letter_position [LETTER_COUNT];

    logic        r_mode;
    logic [1:0]  r_cmd;
    logic [4:0]  r_idx;
    logic        r_letter_ok;
    logic        r_last;
    logic [25:0] r_seen;
    logic [4:0]  r_fill;
    logic        r_complete;
    logic [4:0]  r_held;
    logic        r_held_valid;
    logic [4:0]  r_walk;
    logic [4:0]  r_pa, r_pb;
    logic        r_pair_last;
    logic [4:0]  r_p1, r_p2;
    logic [4:0]  r_k1, r_k2;
    logic [6:0]  r_out_letter;
    logic        r_out_last;
    logic        r_out_valid;

    // case fold, j read as i
    logic [7:0] n_diff;
    logic [4:0] n_idx;
    logic       n_ok;
    always_comb begin
        n_diff = 8'd0;
        n_ok   = 1'b0;
        if (i_letter >= ASCII_LC_A && i_letter <= ASCII_LC_Z) begin
            n_diff = i_letter - ASCII_LC_A;
            n_ok   = 1'b1;
        end else if (i_letter >= ASCII_UC_A && i_letter <= ASCII_UC_Z) begin
            n_diff = i_letter - ASCII_UC_A;
            n_ok   = 1'b1;
        end
        n_idx = n_diff[4:0];
        if (n_idx == IDX_J) n_idx = IDX_I;
    end

    // placement of one letter
    logic [4:0] place_idx;
    logic       place_do;
    always_comb begin
        place_idx = i_ctrl.place_walk ? r_walk : r_idx;
        place_do  = (i_ctrl.place_key || (i_ctrl.place_walk && r_walk != IDX_J))
                    && (r_fill < CELL_LIMIT) && !r_seen[place_idx];
    end

    // output cells from the two positions
    logic [2:0] row1, col1, row2, col2;
    logic [4:0] o1, o2;
    always_comb begin
        row1 = pos_row(r_p1);
        col1 = pos_col(r_p1);
        row2 = pos_row(r_p2);
        col2 = pos_col(r_p2);
        if (row1 == row2) begin
            o1 = cell_of(row1, shift_step(col1, r_mode));
            o2 = cell_of(row2, shift_step(col2, r_mode));
        end else if (col1 == col2) begin
            o1 = cell_of(shift_step(row1, r_mode), col1);
            o2 = cell_of(shift_step(row2, r_mode), col2);
        end else begin
            o1 = cell_of(row1, col2);
            o2 = cell_of(row2, col1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (place_do) begin
            key_square[r_fill]         <= place_idx;
            letter_position[place_idx] <= r_fill;
        end
        if (i_ctrl.pos_read) begin
            r_p1 <= letter_position[r_pa];
            r_p2 <= letter_position[r_pb];
        end
        if (i_ctrl.sq_read) begin
            r_k1 <= key_square[o1];
            r_k2 <= key_square[o2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_item) begin
            r_cmd       <= i_cmd;
            r_idx       <= n_idx;
            r_letter_ok <= n_ok;
            r_last      <= i_last;
        end
        if (i_ctrl.pair_load) begin
            r_pa        <= r_held;
            r_pb        <= i_ctrl.pair_b_x ? IDX_X : r_idx;
            r_pair_last <= i_ctrl.pair_last;
        end
        if (i_ctrl.out_load) begin
            r_out_letter <= 7'(ASCII_UC_A) + 7'(i_ctrl.out_second ? r_k2 : r_k1);
            r_out_last   <= i_ctrl.out_second && r_pair_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= 1'b0;
            r_seen       <= '0;
            r_fill       <= '0;
            r_complete   <= 1'b0;
            r_held       <= '0;
            r_held_valid <= 1'b0;
            r_walk       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) r_mode <= i_cfg_wr_data;
            if (i_ctrl.load_item) r_walk <= '0;
            else if (i_ctrl.place_walk) r_walk <= r_walk + 5'd1;
            if (i_ctrl.clear) begin
                r_seen       <= '0;
                r_fill       <= '0;
                r_complete   <= 1'b0;
                r_held       <= '0;
                r_held_valid <= 1'b0;
            end else begin
                if (place_do) begin
                    r_seen[place_idx] <= 1'b1;
                    r_fill            <= r_fill + 5'd1;
                end
                if (i_ctrl.set_complete) r_complete <= 1'b1;
                if (i_ctrl.hold_set) begin
                    r_held       <= r_idx;
                    r_held_valid <= 1'b1;
                end else if (i_ctrl.hold_clear) begin
                    r_held       <= '0;
                    r_held_valid <= 1'b0;
                end
            end
            if (i_ctrl.out_load) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    assign o_stat.cmd        = r_cmd;
    assign o_stat.letter_ok  = r_letter_ok;
    assign o_stat.last       = r_last;
    assign o_stat.complete   = r_complete;
    assign o_stat.held_valid = r_held_valid;
    assign o_stat.held_eq    = (r_held == r_idx);
    assign o_stat.mode       = r_mode;
    assign o_stat.walk_end   = (r_walk == IDX_LAST);
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    assign o_out_letter = r_out_letter;
    assign o_out_last   = r_out_last;
    assign o_out_valid  = r_out_valid;

endmodule

// ===== sv/playfair_digraph_cipher.sv =====
`timescale 1ns / 1ps
// playfair cipher over a 5x5 key square, one byte per input transaction
// input stream: s_axis_tuser carries the command (clear, key letter, text letter),
//   s_axis_tdata the ascii byte, s_axis_tlast marks the final text byte of a message
// output stream: m_axis_tdata carries one uppercase letter, m_axis_tlast marks
//   the final letter of a message; each digraph gives two output transactions
// config: i_cfg_wr_en writes i_cfg_wr_data as mode (0 encrypt, 1 decrypt); the user
//   must write it only while the block is idle, the block itself does not enforce this
// sequence of controller states after the accepting edge:
//   clear or key byte: decode, then ready again
//   text byte that only gets held, or a skipped byte: decode, text
//   text byte that closes a digraph: decode, text, pos, sq, out1, out2; the two letters
//   are loaded into the output register in out1 and out2
//   a doubled letter with last, or a flush, adds flush, pos, sq, out1, out2 for the pad pair
//   the first text byte after a clear or reset first walks the alphabet to fill the square
// reset (synchronous, active low) empties the square and the held letter and
// sets mode to encrypt; the square contents themselves are not cleared
// when the receiver stalls the output register holds its letter and the sequencer
// waits; the next byte is taken once the second letter sits in the output register
module playfair_digraph_cipher (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] letter
    input  logic [1:0] s_axis_tuser,   // [1:0] command
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [6:0] out_letter, [7] zero
    output logic       m_axis_tlast
);
    import pdc_pkg::*;

    t_ctrl      ctrl;
    t_stat      stat;
    logic [6:0] out_letter;

    // sequencing of key placement, square completion and digraph output
    pdc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    // key square, letter positions, pair state and output register
    pdc_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (s_axis_tuser),
        .i_letter      (s_axis_tdata),
        .i_last        (s_axis_tlast),
        .i_ctrl        (ctrl),
        .o_stat        (stat),
        .o_out_letter  (out_letter),
        .o_out_last    (m_axis_tlast),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready)
    );

    // pad the 7-bit letter to a whole byte
    assign m_axis_tdata = {1'b0, out_letter};

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import pdc_pkg::*;

    // command 3 has no meaning in the block, it must be swallowed
    localparam logic [1:0]  CMD_UNUSED     = 2'd3;
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned DRAIN_CYCLES   = 40;
    localparam int unsigned LONG_HOLD      = 400;
    localparam int unsigned MAX_REPORTS    = 10;
    localparam logic [7:0]  BYTE_X         = ASCII_UC_A + 8'(IDX_X);
    localparam logic [7:0]  CASE_BIT       = 8'h20;

    typedef struct {
        logic [6:0] letter;
        logic       last;
    } t_cipher_letter;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_cfg_wr_en   = 1'b0;
    logic       i_cfg_wr_data = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;  // [7:0] letter
    logic [1:0] s_axis_tuser  = 2'd0;   // [1:0] command
    logic       s_axis_tlast  = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [6:0] out_letter, [7] zero
    logic       m_axis_tlast;

    // predicted square, pair state and mode
    logic [4:0]     key_cell [CELLS];
    logic [4:0]     key_pos [LETTER_COUNT];
    logic [25:0]    key_seen     = '0;
    int unsigned    key_fill     = 0;
    bit             key_full     = 1'b0;
    int             held_index   = 0;
    bit             held_ok      = 1'b0;
    bit             decrypt_mode = 1'b0;
    t_cipher_letter cipher_out_q[$];

    int unsigned items_sent       = 0;
    int unsigned mismatches       = 0;
    int unsigned src_idle_pct     = 0;
    int unsigned sink_idle_pct    = 0;
    int unsigned hold_serial      = 0;
    int unsigned hold_serial_seen = 0;
    int unsigned hold_left        = 0;

    playfair_digraph_cipher i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    // letter index with j folded into i, -1 for anything that is not a letter
    function automatic int letter_index(logic [7:0] b);
        int idx;
        if (b >= ASCII_LC_A && b <= ASCII_LC_Z) idx = int'(b - ASCII_LC_A);
        else if (b >= ASCII_UC_A && b <= ASCII_UC_Z) idx = int'(b - ASCII_UC_A);
        else return -1;
        if (idx == int'(IDX_J)) idx = int'(IDX_I);
        return idx;
    endfunction

    function void place_letter(int idx);
        if (key_fill >= CELLS || key_seen[idx]) return;
        key_cell[key_fill] = 5'(idx);
        key_pos[idx]       = 5'(key_fill);
        key_seen[idx]      = 1'b1;
        key_fill++;
    endfunction

    // row, column or rectangle rule on one digraph, two letters queued
    function void cipher_pair(int a, int b, logic lst);
        int side, step, r1, c1, r2, c2, o1, o2;
        t_cipher_letter e;
        side = SIDE;
        step = decrypt_mode ? side - 1 : 1;
        r1 = int'(key_pos[a]) / side;
        c1 = int'(key_pos[a]) % side;
        r2 = int'(key_pos[b]) / side;
        c2 = int'(key_pos[b]) % side;
        if (r1 == r2) begin
            o1 = r1 * side + (c1 + step) % side;
            o2 = r2 * side + (c2 + step) % side;
        end else if (c1 == c2) begin
            o1 = ((r1 + step) % side) * side + c1;
            o2 = ((r2 + step) % side) * side + c2;
        end else begin
            o1 = r1 * side + c2;
            o2 = r2 * side + c1;
        end
        e.letter = 7'(ASCII_UC_A) + 7'(key_cell[o1]);
        e.last   = 1'b0;
        cipher_out_q.push_back(e);
        e.letter = 7'(ASCII_UC_A) + 7'(key_cell[o2]);
        e.last   = lst;
        cipher_out_q.push_back(e);
    endfunction

    function void predict_cipher_step(logic [1:0] cmd, logic [7:0] data, logic lst);
        int idx, n;
        idx = letter_index(data);
        n   = 0;
        case (cmd)
            CMD_CLEAR: begin
                key_seen   = '0;
                key_fill   = 0;
                key_full   = 1'b0;
                held_index = 0;
                held_ok    = 1'b0;
            end
            CMD_KEY: begin
                if (!key_full && idx >= 0) place_letter(idx);
            end
            CMD_TEXT: begin
                // first text byte completes the square, j never placed
                if (!key_full) begin
                    for (int c = 0; c < LETTER_COUNT; c++)
                        if (c != int'(IDX_J)) place_letter(c);
                    key_full = 1'b1;
                end
                if (idx >= 0) begin
                    if (!held_ok) begin
                        held_index = idx;
                        held_ok    = 1'b1;
                    end else if (!decrypt_mode && held_index == idx) begin
                        // doubled letter split by x, second copy stays held
                        cipher_pair(held_index, IDX_X, 1'b0);
                        n += 2;
                        held_index = idx;
                    end else begin
                        cipher_pair(held_index, idx, lst);
                        n += 2;
                        held_ok    = 1'b0;
                        held_index = 0;
                    end
                end
                if (lst) begin
                    // lone letter padded with x, even if the byte was skipped
                    if (held_ok) begin
                        cipher_pair(held_index, IDX_X, 1'b1);
                        n += 2;
                    end else if (n > 0) begin
                        cipher_out_q[cipher_out_q.size() - 1].last = 1'b1;
                    end
                    held_ok    = 1'b0;
                    held_index = 0;
                end
            end
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------- drivers

    // one input transaction, random gap in front, prediction at the accepting edge
    task automatic send_item(logic [1:0] cmd, logic [7:0] data, logic lst);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= data;
        s_axis_tlast  <= lst;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_cipher_step(cmd, data, lst);
        if (cmd != CMD_UNUSED) items_sent++;
    endtask

    // all letters delivered, then room for a walk or a held byte to finish
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (cipher_out_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_mode(bit dec);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= dec;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        decrypt_mode = dec;
    endtask

    task automatic set_idling(int unsigned src_pct, int unsigned sink_pct);
        src_idle_pct = src_pct;
        sink_idle_pct <= sink_pct;
    endtask

    function automatic logic [7:0] key_byte();
        if ($urandom_range(99) < 15) return 8'($urandom);
        return (ASCII_UC_A + 8'($urandom_range(25))) | (CASE_BIT & {8{1'($urandom)}});
    endfunction

    // repeats and x are common so doubled letters and xx pairs show up
    function automatic logic [7:0] text_byte(logic [7:0] prev);
        int unsigned pick;
        logic [7:0]  flip;
        pick = $urandom_range(99);
        flip = CASE_BIT & {8{1'($urandom)}};
        if (pick < 15) return prev ^ flip;
        if (pick < 25) return BYTE_X | flip;
        if (pick < 35) return 8'($urandom);
        return (ASCII_UC_A + 8'($urandom_range(25))) | flip;
    endfunction

    // clear, key, then a text message ending in last; sometimes the old square is reused
    task automatic send_message();
        int unsigned key_len, text_len, start;
        bit          whole_alphabet;
        logic [7:0]  prev;
        whole_alphabet = ($urandom_range(9) == 0);
        key_len  = whole_alphabet ? 28 : $urandom_range(0, 8);
        start    = $urandom_range(25);
        text_len = $urandom_range(1, 9);
        prev     = ASCII_UC_A;
        if ($urandom_range(9) < 7) begin
            send_item(CMD_CLEAR, 8'($urandom), 1'($urandom));
            for (int k = 0; k < key_len; k++) begin
                if (whole_alphabet)
                    send_item(CMD_KEY, (ASCII_UC_A + 8'((start + k) % 26))
                              | (CASE_BIT & {8{1'($urandom)}}), 1'($urandom));
                else
                    send_item(CMD_KEY, key_byte(), 1'($urandom));
            end
        end
        for (int i = 0; i < text_len; i++) begin
            prev = text_byte(prev);
            send_item(CMD_TEXT, prev, i == text_len - 1);
        end
    endtask

    // ---------------------------------------------------------------- receiver side

    // a new hold request shuts the output for a long stretch, else random stalls
    always @(posedge i_clk) begin
        if (hold_serial != hold_serial_seen) begin
            hold_serial_seen <= hold_serial;
            hold_left        <= LONG_HOLD;
            m_axis_tready    <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    function void report_mismatch(string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("mismatch: %s", msg);
    endfunction

    // sample at the edge, compare at the falling edge after the prediction is queued
    always @(posedge i_clk) begin : output_check
        logic           took, got_last;
        logic [7:0]     got_data;
        t_cipher_letter want;
        took     = i_rst_n && m_axis_tvalid && m_axis_tready;
        got_data = m_axis_tdata;
        got_last = m_axis_tlast;
        if (took) begin
            @(negedge i_clk);
            if (cipher_out_q.size() == 0) begin
                report_mismatch($sformatf("unexpected letter 0x%02h last %0b",
                                          got_data, got_last));
            end else begin
                want = cipher_out_q.pop_front();
                if (got_data !== {1'b0, want.letter})
                    report_mismatch($sformatf("letter expected 0x%02h got 0x%02h",
                                              {1'b0, want.letter}, got_data));
                if (got_last !== want.last)
                    report_mismatch($sformatf("last expected %0b got %0b (letter 0x%02h)",
                                              want.last, got_last, got_data));
            end
        end
    end

    // ends the run when no transaction moves on either side for too long
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL");
        $finish;
    end

    // ---------------------------------------------------------------- tests

    // key "play" with skipped bytes, then the special cases of the text path
    task automatic test_directed();
        set_idling(11, 48);
        send_item(CMD_UNUSED, "A", 1'b1);
        send_item(CMD_KEY, "p", 1'b1);      // last is ignored on key bytes
        send_item(CMD_KEY, "L", 1'b0);
        send_item(CMD_KEY, "a", 1'b0);
        send_item(CMD_KEY, "y", 1'b0);
        send_item(CMD_KEY, "!", 1'b0);      // not a letter
        send_item(CMD_KEY, "j", 1'b0);      // placed as i
        send_item(CMD_KEY, "P", 1'b0);      // already seen
        send_item(CMD_TEXT, 8'h00, 1'b0);   // completes the square, emits nothing
        send_item(CMD_KEY, "Q", 1'b0);      // square already full
        send_item(CMD_TEXT, "h", 1'b0);
        send_item(CMD_TEXT, "i", 1'b0);     // rectangle
        send_item(CMD_TEXT, "p", 1'b0);
        send_item(CMD_TEXT, "Y", 1'b0);     // same row
        send_item(CMD_TEXT, "E", 1'b0);
        send_item(CMD_TEXT, "e", 1'b0);     // doubled, ex in one column
        send_item(CMD_TEXT, "Z", 1'b0);
        send_item(CMD_TEXT, "x", 1'b0);
        send_item(CMD_TEXT, "X", 1'b1);     // xx twice, four letters
        send_item(CMD_TEXT, ".", 1'b1);     // last with nothing held
        send_item(CMD_TEXT, "a", 1'b0);
        send_item(CMD_TEXT, "#", 1'b1);     // skipped byte flushes the held a
        wait_idle();
        set_mode(1'b1);
        send_item(CMD_CLEAR, 8'hff, 1'b1);
        send_item(CMD_KEY, "k", 1'b0);
        send_item(CMD_TEXT, "A", 1'b0);
        send_item(CMD_TEXT, "a", 1'b0);     // doubled letters are not split here
        send_item(CMD_TEXT, "B", 1'b0);
        send_item(CMD_TEXT, "z", 1'b0);
        send_item(CMD_TEXT, "q", 1'b1);     // odd tail padded in decrypt too
        wait_idle();
    endtask

    task automatic test_random_traffic(int unsigned src_pct, int unsigned sink_pct,
                                       bit dec, int unsigned count);
        int unsigned goal;
        goal = items_sent + count;
        set_idling(src_pct, sink_pct);
        set_mode(dec);
        while (items_sent < goal) begin
            if ($urandom_range(99) < 15)
                send_item(2'($urandom_range(3)), 8'($urandom), 1'($urandom));
            else
                send_message();
        end
        wait_idle();
    endtask

    // output shut while the sender keeps offering, the block has to stall its input
    task automatic test_output_backpressure();
        set_idling(0, 0);
        set_mode(1'b0);
        hold_serial <= hold_serial + 1;
        send_item(CMD_CLEAR, 8'h00, 1'b0);
        repeat (4) send_item(CMD_KEY, key_byte(), 1'b0);
        for (int i = 0; i < 12; i++)
            send_item(CMD_TEXT, ASCII_LC_A + 8'($urandom_range(25)), i == 11);
        wait_idle();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_traffic(11, 48, 1'b0, 20);
        test_random_traffic(48, 11, 1'b1, 20);
        test_random_traffic(0, 0, 1'b0, 20);
        test_output_backpressure();
        if (mismatches == 0 && cipher_out_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
sv/pdc_pkg.sv
sv/pdc_ctrl.sv
sv/pdc_datapath.sv
sv/playfair_digraph_cipher.sv
tb/testbench.sv
